@@ rtl/slm_pkg.sv @@
// ----------------------------------------------------------------------------
// slm_pkg
// Types and codes shared by the sorted list merge block.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam logic [1:0] ACT_APPEND_A = 2'd0;
  localparam logic [1:0] ACT_APPEND_B = 2'd1;
  localparam logic [1:0] ACT_MERGE    = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic               last;
    logic               empty_res;
    logic               overflow;
  } out_t;

  typedef enum logic [1:0] {
    CMD_APPEND_A,
    CMD_APPEND_B,
    CMD_MERGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] value;
  } cmd_t;

endpackage

@@ rtl/slm_ram.sv @@
// ----------------------------------------------------------------------------
// slm_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/slm_front.sv @@
// ----------------------------------------------------------------------------
// slm_front
// Accepts input items, decodes the action and queues commands for the
// back end. Unused action codes are dropped here.
// ----------------------------------------------------------------------------
module slm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  slm_pkg::in_t  in_data,
  output logic          cmd_valid,
  output slm_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  import slm_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       known;
  cmd_t       dec;

  always_comb begin
    known     = 1'b1;
    dec.value = in_data.value;
    dec.kind  = CMD_MERGE;
    case (in_data.action)
      ACT_APPEND_A: dec.kind = CMD_APPEND_A;
      ACT_APPEND_B: dec.kind = CMD_APPEND_B;
      ACT_MERGE:    dec.kind = CMD_MERGE;
      default:      known = 1'b0;
    endcase
  end

  assign in_stall  = (fill_r == 2'd2);
  assign push      = in_valid && !in_stall && known;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ cmd_pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid) else $error("pop from empty command queue");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3) else $error("command queue fill out of range");

  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cmd_pop) |=> (fill_r == $past(fill_r) + 2'd1))
    else $error("command queue fill lost a push");

endmodule

@@ rtl/slm_back.sv @@
// ----------------------------------------------------------------------------
// slm_back
// Executes queued commands: appends into the list RAMs, and runs the
// two-pointer merge into the output register.
// ----------------------------------------------------------------------------
module slm_back #(
  parameter int LIST_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  slm_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output slm_pkg::out_t out_data
);

  import slm_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_PICK,
    S_EMPTY
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic          drop_r, drop_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic          we_a, we_b;
  logic [31:0]   head_a, head_b;
  logic          out_free;
  logic          take_a;
  logic          load_out;

  slm_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (we_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (cmd.value),
    .rd_addr (ia_r[AW-1:0]),
    .rd_data (head_a)
  );

  slm_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (we_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (cmd.value),
    .rd_addr (ib_r[AW-1:0]),
    .rd_data (head_b)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign take_a = (ia_r < cnt_a_r) &&
                  ((ib_r >= cnt_b_r) || ($signed(head_a) <= $signed(head_b)));

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    drop_nxt      = drop_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    we_a          = 1'b0;
    we_b          = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_APPEND_A: begin
              if (cnt_a_r < FULL) begin
                we_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_APPEND_B: begin
              if (cnt_b_r < FULL) begin
                we_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_MERGE: begin
              ovf_nxt = drop_r;
              ia_nxt  = '0;
              ib_nxt  = '0;
              if (cnt_a_r == '0 && cnt_b_r == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                state_nxt = S_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (out_free) begin
          load_out             = 1'b1;
          out_valid_nxt        = 1'b1;
          out_nxt.merged_value = take_a ? head_a : head_b;
          out_nxt.empty_res    = 1'b0;
          out_nxt.overflow     = ovf_r;
          if (take_a) begin
            ia_nxt = ia_r + CW'(1);
          end else begin
            ib_nxt = ib_r + CW'(1);
          end
          out_nxt.last = (ia_nxt == cnt_a_r) && (ib_nxt == cnt_b_r);
          if (out_nxt.last) begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          load_out             = 1'b1;
          out_valid_nxt        = 1'b1;
          out_nxt.merged_value = '0;
          out_nxt.last         = 1'b1;
          out_nxt.empty_res    = 1'b1;
          out_nxt.overflow     = ovf_r;
          drop_nxt             = 1'b0;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ia_r  <= ia_nxt;
    ib_r  <= ib_nxt;
    ovf_r <= ovf_nxt;
    out_r <= out_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= FULL) && (cnt_b_r <= FULL)) else $error("list count overrun");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> ((ia_r < cnt_a_r) || (ib_r < cnt_b_r)))
    else $error("merge pointers past both lists");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && out_nxt.last) |=>
      (cnt_a_r == '0 && cnt_b_r == '0 && !drop_r && state_r == S_IDLE))
    else $error("merge end did not clear lists");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE)) else $error("command taken during merge");

endmodule

@@ rtl/sorted_list_merge_top.sv @@
// ----------------------------------------------------------------------------
// sorted_list_merge_top
// Stable two-way merge of two lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): action 0 appends value to
// list A, 1 to list B, 2 merges and emits, 3 is ignored. Appends to a full
// list are dropped and set a sticky overflow flag.
// Result channel (out_valid / out_stall / out_data): a merge gives every
// stored value in ascending order, list A first on ties, last set on the
// final one; with both lists empty a single result with empty_res set.
// overflow is reported on each merge result; the merge clears lists and flag.
// Queueing: a two-entry command queue sits behind the input. The executor
// takes an append straight from the queue. A merge handles each element in
// the states S_LOAD (RAM read) and then S_PICK (compare and load of the
// output register); S_PICK waits while the result register is held. Inputs
// queue up while a merge runs.
// Reset clears counts, flag, queue and output valid; RAM contents are kept.
// While out_stall is high with a result valid, the result register holds and the merge waits.
// ----------------------------------------------------------------------------
module sorted_list_merge_top #(
  parameter int LIST_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  slm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output slm_pkg::out_t out_data
);

  import slm_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  slm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  slm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
